FILE: hdl/rpq_pkg.sv
// ---------------------------------------------------------------------------
// rpq_pkg
// Shared constants and cell control types for the sorted makespan block.
// ---------------------------------------------------------------------------
package rpq_pkg;

  // default sizing
  localparam int MAX_TASKS_DEF = 64;
  localparam int TIME_BITS_DEF = 16;

  // fixed port widths
  localparam int IN_TIME_W = 16;
  localparam int SPAN_W    = 24;
  localparam int CNT_OUT_W = 7;

  localparam logic [SPAN_W-1:0] SPAN_LIMIT = '1;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_SHIFT
  } rpq_op_t;

  typedef struct packed {
    rpq_op_t op;
    logic    parity;
    logic    mode;
  } rpq_cell_ctrl_t;

endpackage

FILE: hdl/rpq_task_if.sv
// ---------------------------------------------------------------------------
// rpq_task_if
// Task channel: one word carries release, processing and tail times.
// ---------------------------------------------------------------------------
interface rpq_task_if;
  logic                          valid;
  logic                          ready;
  logic [rpq_pkg::IN_TIME_W-1:0] release_time;
  logic [rpq_pkg::IN_TIME_W-1:0] processing_time;
  logic [rpq_pkg::IN_TIME_W-1:0] tail_time;
  logic                          last_task;

  modport source (
    output valid, release_time, processing_time, tail_time, last_task,
    input  ready
  );
  modport sink (
    input  valid, release_time, processing_time, tail_time, last_task,
    output ready
  );
endinterface

FILE: hdl/rpq_result_if.sv
// ---------------------------------------------------------------------------
// rpq_result_if
// Result channel: one word per task set with the makespan and flags.
// ---------------------------------------------------------------------------
interface rpq_result_if;
  logic                          valid;
  logic                          ready;
  logic [rpq_pkg::SPAN_W-1:0]    makespan;
  logic [rpq_pkg::CNT_OUT_W-1:0] task_count;
  logic                          overflow;
  logic                          saturated;

  modport source (
    output valid, makespan, task_count, overflow, saturated,
    input  ready
  );
  modport sink (
    input  valid, makespan, task_count, overflow, saturated,
    output ready
  );
endinterface

FILE: hdl/rpq_sorted_makespan.sv
// Loading takes one task word per cycle while in the load state; after
// the word with last_task the tasks are sorted by odd-even transposition
// and drained through cell 0 into the accumulator, and the result word
// is written once the output is free. No new task set is taken until
// then. Reset empties the chain, clears the count and drop flag, and
// sets the sort mode register to 1.
// ---------------------------------------------------------------------------
// rpq_sorted_makespan
// Chain of task cells with odd-even transposition sort and a schedule
// accumulator fed from the head of the chain.
// ---------------------------------------------------------------------------
module rpq_sorted_makespan #(
  parameter int MAX_TASKS = rpq_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = rpq_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rpq_task_if.sink      in_task,
  rpq_result_if.source  out_res,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import rpq_pkg::*;

  localparam int EW     = 4*TIME_BITS + 1;
  localparam int CNT_W  = $clog2(MAX_TASKS+1);
  localparam int FIN_W  = TIME_BITS + CNT_W + 1;
  localparam int BEST_W = FIN_W + 1;
  localparam int EXT_W  = (BEST_W > SPAN_W) ? BEST_W : SPAN_W + 1;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SORT,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     phase_r, phase_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 mode_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0]    makespan_r, makespan_nxt;
  logic [CNT_OUT_W-1:0] task_count_r, task_count_nxt;
  logic                 overflow_r, overflow_nxt;
  logic                 saturated_r, saturated_nxt;

  logic                 in_fire, has_room, hand_off;
  rpq_cell_ctrl_t       ctrl;
  logic [TIME_BITS-1:0] in_rel, in_proc, in_tail;
  logic [EW-1:0]        new_ent;

  logic [EW-1:0]        ent_w   [0:MAX_TASKS];
  logic [EW-1:0]        lent_w  [0:MAX_TASKS-1];
  logic                 valid_w [0:MAX_TASKS];
  logic                 swp_w   [0:MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_vec;

  logic                 feed;
  logic [BEST_W-1:0]    best_w;
  logic [EXT_W-1:0]     best_ext;
  logic                 over_limit;

  // input word, trimmed to the time width
  assign in_rel  = TIME_BITS'(in_task.release_time);
  assign in_proc = TIME_BITS'(in_task.processing_time);
  assign in_tail = TIME_BITS'(in_task.tail_time);
  assign new_ent = {in_rel, in_proc, in_tail,
                    (TIME_BITS+1)'(in_rel) + (TIME_BITS+1)'(in_tail)};

  assign in_task.ready = (state_r == S_LOAD);
  assign in_fire       = in_task.valid && in_task.ready;
  assign has_room      = (count_r < CNT_W'(MAX_TASKS));
  assign hand_off      = (state_r == S_DONE) && (!out_valid_r || out_res.ready);

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // cell chain control
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.parity = phase_r[0];
    ctrl.mode   = mode_r;
    unique case (state_r)
      S_LOAD:  if (in_fire && has_room) ctrl.op = OP_LOAD;
      S_SORT:  ctrl.op = OP_SORT;
      S_DRAIN: if (valid_w[0]) ctrl.op = OP_SHIFT;
      S_DONE:  ctrl.op = OP_HOLD;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  // chain ends: nothing beyond the last cell, no swap into the first
  assign ent_w[MAX_TASKS]   = '0;
  assign valid_w[MAX_TASKS] = 1'b0;
  assign swp_w[0]           = 1'b0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lent_w[g] = '0;
    end else begin : g_body
      assign lent_w[g] = ent_w[g-1];
    end

    rpq_cell #(
      .TIME_BITS (TIME_BITS),
      .CNT_W     (CNT_W),
      .IDX       (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl_i        (ctrl),
      .count_i       (count_r),
      .new_ent_i     (new_ent),
      .left_ent_i    (lent_w[g]),
      .left_swap_i   (swp_w[g]),
      .right_ent_i   (ent_w[g+1]),
      .right_valid_i (valid_w[g+1]),
      .ent_o         (ent_w[g]),
      .valid_o       (valid_w[g]),
      .swap_o        (swp_w[g+1])
    );

    assign valid_vec[g] = valid_w[g];
  end

  // schedule accumulator fed from the head cell
  assign feed = (state_r == S_DRAIN) && valid_w[0];

  rpq_sched #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .feed_i  (feed),
    .clear_i (hand_off),
    .rel_i   (ent_w[0][EW-1 -: TIME_BITS]),
    .proc_i  (ent_w[0][EW-1-TIME_BITS -: TIME_BITS]),
    .tail_i  (ent_w[0][EW-1-2*TIME_BITS -: TIME_BITS]),
    .best_o  (best_w)
  );

  assign best_ext   = EXT_W'(best_w);
  assign over_limit = best_ext > EXT_W'(SPAN_LIMIT);

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    phase_nxt      = phase_r;
    dropped_nxt    = dropped_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    makespan_nxt   = makespan_r;
    task_count_nxt = task_count_r;
    overflow_nxt   = overflow_r;
    saturated_nxt  = saturated_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            count_nxt = count_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_task.last_task) begin
            phase_nxt = '0;
            state_nxt = S_SORT;
          end
        end
      end
      S_SORT: begin
        phase_nxt = phase_r + 1'b1;
        if (CNT_W'(phase_r + 1'b1) >= count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!valid_w[0]) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (hand_off) begin
          out_valid_nxt  = 1'b1;
          makespan_nxt   = over_limit ? SPAN_LIMIT : SPAN_W'(best_ext);
          task_count_nxt = CNT_OUT_W'(count_r);
          overflow_nxt   = dropped_r;
          saturated_nxt  = over_limit;
          count_nxt      = '0;
          dropped_nxt    = 1'b0;
          state_nxt      = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      phase_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    makespan_r   <= makespan_nxt;
    task_count_r <= task_count_nxt;
    overflow_r   <= overflow_nxt;
    saturated_r  <= saturated_nxt;
  end

  // result word
  assign out_res.valid      = out_valid_r;
  assign out_res.makespan   = makespan_r;
  assign out_res.task_count = task_count_r;
  assign out_res.overflow   = overflow_r;
  assign out_res.saturated  = saturated_r;

  // occupied cells match the task count while loading and sorting
  a_cells_match_count: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD || state_r == S_SORT) |-> ($countones(valid_vec) == count_r)
  ) else $error("occupied cells differ from task count");

  // the chain is empty once the drain has finished
  a_chain_empty_when_done: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (valid_vec == '0)
  ) else $error("cells still occupied after drain");

  // a dropped task means the store was full
  a_overflow_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    (hand_off && dropped_r) |-> (count_r == CNT_W'(MAX_TASKS))
  ) else $error("overflow flagged with free cells");

  // a new result is only written once the previous word has gone
  a_no_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(makespan_r))
  ) else $error("pending result overwritten");

endmodule

FILE: hdl/rpq_cell.sv
// ---------------------------------------------------------------------------
// rpq_cell
// One slot of the task chain: loads a task, swaps with its right-hand
// neighbour during odd-even transposition sorting, and shifts left on drain.
// ---------------------------------------------------------------------------
module rpq_cell #(
  parameter int TIME_BITS = rpq_pkg::TIME_BITS_DEF,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpq_pkg::rpq_cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [4*TIME_BITS:0]   new_ent_i,
  input  logic [4*TIME_BITS:0]   left_ent_i,
  input  logic                   left_swap_i,
  input  logic [4*TIME_BITS:0]   right_ent_i,
  input  logic                   right_valid_i,
  output logic [4*TIME_BITS:0]   ent_o,
  output logic                   valid_o,
  output logic                   swap_o
);
  import rpq_pkg::*;

  localparam int   EW       = 4*TIME_BITS + 1;
  localparam logic CELL_PAR = 1'(IDX % 2);

  logic [EW-1:0]        ent_r, ent_nxt;
  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] own_rel, right_rel;
  logic [TIME_BITS:0]   own_sum, right_sum;
  logic                 right_first;

  // entry layout: release, processing, tail, release plus tail
  assign own_rel   = ent_r[EW-1 -: TIME_BITS];
  assign right_rel = right_ent_i[EW-1 -: TIME_BITS];
  assign own_sum   = ent_r[TIME_BITS:0];
  assign right_sum = right_ent_i[TIME_BITS:0];

  // strict order keeps equal keys in arrival order
  assign right_first = ctrl_i.mode ? (right_sum > own_sum) : (right_rel < own_rel);

  assign swap_o = (ctrl_i.op == OP_SORT) && (ctrl_i.parity == CELL_PAR) &&
                  valid_r && right_valid_i && right_first;

  // next slot contents
  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    unique case (ctrl_i.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        if (count_i == CNT_W'(IDX)) begin
          ent_nxt   = new_ent_i;
          valid_nxt = 1'b1;
        end
      end
      OP_SORT: begin
        if (swap_o) begin
          ent_nxt = right_ent_i;
        end else if (left_swap_i) begin
          ent_nxt = left_ent_i;
        end
      end
      OP_SHIFT: begin
        ent_nxt   = right_ent_i;
        valid_nxt = right_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o   = ent_r;
  assign valid_o = valid_r;

endmodule

FILE: hdl/rpq_sched.sv
// ---------------------------------------------------------------------------
// rpq_sched
// Single-machine schedule accumulator: takes tasks in sorted order, tracks
// the running finish time and the largest finish plus tail.
// ---------------------------------------------------------------------------
module rpq_sched #(
  parameter int MAX_TASKS = rpq_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = rpq_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 feed_i,
  input  logic                 clear_i,
  input  logic [TIME_BITS-1:0] rel_i,
  input  logic [TIME_BITS-1:0] proc_i,
  input  logic [TIME_BITS-1:0] tail_i,
  output logic [TIME_BITS+$clog2(MAX_TASKS+1)+1:0] best_o
);
  import rpq_pkg::*;

  localparam int FIN_W  = TIME_BITS + $clog2(MAX_TASKS+1) + 1;
  localparam int BEST_W = FIN_W + 1;

  logic [FIN_W-1:0]     finish_r, finish_nxt, start_val;
  logic [TIME_BITS-1:0] tail_d_r;
  logic                 a_valid_r;
  logic [BEST_W-1:0]    best_r, done_val;

  // first stage: start no earlier than release, then run
  assign start_val  = (FIN_W'(rel_i) > finish_r) ? FIN_W'(rel_i) : finish_r;
  assign finish_nxt = start_val + FIN_W'(proc_i);

  // second stage: delivery time of the task just scheduled
  assign done_val = BEST_W'(finish_r) + BEST_W'(tail_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      finish_r  <= '0;
      a_valid_r <= 1'b0;
      best_r    <= '0;
    end else begin
      a_valid_r <= feed_i;
      if (feed_i) begin
        finish_r <= finish_nxt;
      end
      if (a_valid_r && (done_val > best_r)) begin
        best_r <= done_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feed_i) begin
      tail_d_r <= tail_i;
    end
  end

  assign best_o = best_r;

endmodule
